// File: sv/wsm_pkg.sv
// Shared types and constants for the wildcard signature matcher.
// No dependencies.
package wsm_pkg;

   // item kinds carried on req_tuser
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_SCAN = 1'b1
   } op_type;

   localparam int NUM_SLOTS_DEF       = 16;
   localparam int MAX_PATTERN_LEN_DEF = 32;

   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 4;
   localparam int POS_W    = 5;
   localparam int SHIFT_W  = 2;
   localparam int MASK_W   = 16;
   localparam int OFFSET_W = 25;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   localparam logic [SHIFT_W-1:0]  ALIGN_SHIFT_RESET = 2'd1;
   localparam logic [OFFSET_W-1:0] SEEN_MAX          = {OFFSET_W{1'b1}};

endpackage

// File: sv/wildcard_signature_matcher.sv
// Wildcard signature matcher: byte window against a table of anchored signatures.
// Depends on wsm_pkg.
// A checked scan word enters the compare stage; its result is then held in the output
// register until taken. Throughput: one word per cycle unless the output stalls, set
// by the single compare stage that tests every slot against the window in parallel.
// Reset (synchronous): window, offset counter, care bits and slot valid bits clear,
// align_shift returns to 1, no result pending.
module wildcard_signature_matcher #(
   parameter int NUM_SLOTS       = wsm_pkg::NUM_SLOTS_DEF,
   parameter int MAX_PATTERN_LEN = wsm_pkg::MAX_PATTERN_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] byte_value, [11:8] slot_index, [16:12] slot_position,
   // [17] must_match, [18] stream_start, [23:19] zero
   input  logic [wsm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] found, [4:1] first_hit, [20:5] hit_mask, [45:21] start_offset, [47:46] zero
   output logic [wsm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [wsm_pkg::SHIFT_W-1:0]     csr_wdata
);

   localparam int HIT_W   = (NUM_SLOTS > wsm_pkg::MASK_W) ? NUM_SLOTS : wsm_pkg::MASK_W;
   localparam int FIRST_W = $clog2(HIT_W);

   // input word fields
   logic [wsm_pkg::BYTE_W-1:0] req_byte;
   logic [wsm_pkg::SLOT_W-1:0] req_slot;
   logic [wsm_pkg::POS_W-1:0]  req_pos;
   logic                       req_must;
   logic                       req_start;
   logic                       req_op;

   assign req_byte  = req_tdata[7:0];
   assign req_slot  = req_tdata[11:8];
   assign req_pos   = req_tdata[16:12];
   assign req_must  = req_tdata[17];
   assign req_start = req_tdata[18];
   assign req_op    = req_tuser;

   // state
   logic [wsm_pkg::SHIFT_W-1:0]  align_ff;
   logic [wsm_pkg::BYTE_W-1:0]   win_ff [MAX_PATTERN_LEN];
   logic [wsm_pkg::BYTE_W-1:0]   win_in [MAX_PATTERN_LEN];
   logic [wsm_pkg::BYTE_W-1:0]   pat_ff [NUM_SLOTS][MAX_PATTERN_LEN];
   logic                         care_ff [NUM_SLOTS][MAX_PATTERN_LEN];
   logic [NUM_SLOTS-1:0]         valid_ff;
   logic [wsm_pkg::OFFSET_W-1:0] seen_ff, seen_in;
   logic                         chk_ff, chk_in;
   logic [wsm_pkg::OFFSET_W-1:0] ofs_ff, ofs_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff;
   logic [wsm_pkg::SLOT_W-1:0]   first_ff;
   logic [wsm_pkg::MASK_W-1:0]   mask_ff;
   logic [wsm_pkg::OFFSET_W-1:0] rsp_ofs_ff;

   logic accept, advance, is_scan, wr_en, sat, scan_chk;
   logic [wsm_pkg::OFFSET_W-1:0] seen_base, seen_next, ofs_next;
   logic [2:0]                   align_mask;
   logic [HIT_W-1:0]             hit;
   logic [FIRST_W-1:0]           first;

   // output stage frees up when empty or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !chk_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign is_scan    = (req_op == wsm_pkg::OP_SCAN);
   assign wr_en      = accept && !is_scan && (32'(req_slot) < NUM_SLOTS)
                       && (32'(req_pos) < MAX_PATTERN_LEN);

   always_comb begin
      seen_base  = req_start ? '0 : seen_ff;
      sat        = (seen_base == wsm_pkg::SEEN_MAX);
      seen_next  = sat ? seen_base : seen_base + 1'b1;
      ofs_next   = seen_next - wsm_pkg::OFFSET_W'(MAX_PATTERN_LEN);
      align_mask = 3'((4'd1 << align_ff) - 4'd1);
      scan_chk   = !sat && (seen_next >= wsm_pkg::OFFSET_W'(MAX_PATTERN_LEN))
                   && ((ofs_next[2:0] & align_mask) == 3'd0);
      for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) begin
         win_in[i] = req_start ? '0 : win_ff[i+1];
      end
      win_in[MAX_PATTERN_LEN-1] = req_byte;
   end

   always_comb begin
      seen_in = seen_ff;
      ofs_in  = ofs_ff;
      chk_in  = chk_ff;
      if (accept) begin
         chk_in = is_scan && scan_chk;
         if (is_scan) begin
            seen_in = seen_next;
            ofs_in  = ofs_next;
         end
      end else if (advance) begin
         chk_in = 1'b0;
      end
      rsp_valid_in = chk_ff ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);
   end

   // compare all slots against the current window
   always_comb begin
      hit = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         hit[s] = valid_ff[s];
         for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (care_ff[s][p] && (win_ff[p] != pat_ff[s][p])) begin
               hit[s] = 1'b0;
            end
         end
      end
      first = '0;
      for (int s = HIT_W - 1; s >= 0; s--) begin
         if (hit[s]) begin
            first = FIRST_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff     <= wsm_pkg::ALIGN_SHIFT_RESET;
         seen_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            win_ff[i] <= '0;
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
               care_ff[s][p] <= 1'b0;
            end
         end
      end else begin
         if (csr_we) begin
            align_ff <= csr_wdata;
         end
         seen_ff      <= seen_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && is_scan) begin
            win_ff <= win_in;
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (wr_en && (32'(req_slot) == s)) begin
               valid_ff[s] <= 1'b1;
            end
            for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
               if (wr_en && (32'(req_slot) == s) && (32'(req_pos) == p)) begin
                  care_ff[s][p] <= req_must;
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ofs_ff <= ofs_in;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (wr_en && (32'(req_slot) == s) && (32'(req_pos) == p)) begin
               pat_ff[s][p] <= req_byte;
            end
         end
      end
      if (chk_ff && advance) begin
         found_ff   <= |hit;
         first_ff   <= first[wsm_pkg::SLOT_W-1:0];
         mask_ff    <= hit[wsm_pkg::MASK_W-1:0];
         rsp_ofs_ff <= ofs_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ofs_ff, mask_ff, first_ff, found_ff};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_signature_matcher: loads signatures, plants
// them in scanned streams and checks every result word against a local predictor.
// Depends on wsm_pkg and the wildcard_signature_matcher RTL.

localparam int NSLOT = wsm_pkg::NUM_SLOTS_DEF;
localparam int WLEN  = wsm_pkg::MAX_PATTERN_LEN_DEF;

typedef struct packed {
   logic [wsm_pkg::OFFSET_W-1:0] start_offset;
   logic [wsm_pkg::MASK_W-1:0]   hit_mask;
   logic [wsm_pkg::SLOT_W-1:0]   first_hit;
   logic                         found;
} scan_report_type;

class hit_scoreboard;
   logic [wsm_pkg::BYTE_W-1:0]   window [WLEN];
   logic [wsm_pkg::BYTE_W-1:0]   sig_byte [NSLOT][WLEN];
   logic                         sig_care [NSLOT][WLEN];
   logic [NSLOT-1:0]             slot_loaded;
   logic [wsm_pkg::OFFSET_W-1:0] seen;
   logic [wsm_pkg::SHIFT_W-1:0]  align_shift;
   scan_report_type              expected_hits [$];
   int                           errors;

   function new();
      foreach (window[i]) window[i] = '0;
      foreach (sig_byte[s, p]) begin
         sig_byte[s][p] = '0;
         sig_care[s][p] = 1'b0;
      end
      slot_loaded = '0;
      seen        = '0;
      align_shift = wsm_pkg::ALIGN_SHIFT_RESET;
      errors      = 0;
   endfunction

   // Track one accepted request word; a checked scan queues its report.
   function void note_word(wsm_pkg::op_type op, logic [wsm_pkg::REQ_DATA_W-1:0] data);
      logic [wsm_pkg::BYTE_W-1:0]   b;
      logic [wsm_pkg::SLOT_W-1:0]   slot;
      logic [wsm_pkg::POS_W-1:0]    pos;
      logic                         at_limit;
      logic                         hit;
      logic [wsm_pkg::OFFSET_W-1:0] offset;
      scan_report_type              rep;
      b    = data[7:0];
      slot = data[11:8];
      pos  = data[16:12];
      if (op == wsm_pkg::OP_LOAD) begin
         sig_byte[slot][pos] = b;
         sig_care[slot][pos] = data[17];
         slot_loaded[slot]   = 1'b1;
         return;
      end
      if (data[18]) begin
         foreach (window[i]) window[i] = '0;
         seen = '0;
      end
      for (int i = 0; i < WLEN - 1; i++) window[i] = window[i+1];
      window[WLEN-1] = b;
      at_limit = (seen == wsm_pkg::SEEN_MAX);
      if (!at_limit) seen++;
      if (at_limit || seen < WLEN) return;
      offset = seen - wsm_pkg::OFFSET_W'(WLEN);
      if ((offset & ((25'd1 << align_shift) - 25'd1)) != '0) return;
      rep = '0;
      rep.start_offset = offset;
      for (int s = 0; s < NSLOT; s++) begin
         hit = slot_loaded[s];
         for (int p = 0; p < WLEN; p++)
            if (sig_care[s][p] && window[p] != sig_byte[s][p]) hit = 1'b0;
         if (hit) begin
            if (!rep.found) rep.first_hit = wsm_pkg::SLOT_W'(s);
            rep.found       = 1'b1;
            rep.hit_mask[s] = 1'b1;
         end
      end
      expected_hits.push_back(rep);
   endfunction

   function void check_result(logic [wsm_pkg::RSP_DATA_W-1:0] data);
      scan_report_type want;
      if (expected_hits.size() == 0) begin
         $error("result word with no scan pending: %h", data);
         errors++;
         return;
      end
      want = expected_hits.pop_front();
      if (data[0] !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, data[0]);
         errors++;
      end
      if (data[4:1] !== want.first_hit) begin
         $error("first_hit: expected %0d, got %0d", want.first_hit, data[4:1]);
         errors++;
      end
      if (data[20:5] !== want.hit_mask) begin
         $error("hit_mask: expected %h, got %h", want.hit_mask, data[20:5]);
         errors++;
      end
      if (data[45:21] !== want.start_offset) begin
         $error("start_offset: expected %0d, got %0d", want.start_offset, data[45:21]);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 132;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [wsm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [wsm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [wsm_pkg::SHIFT_W-1:0]    csr_wdata  = '0;

   hit_scoreboard sb;
   int cycle_count = 0;
   int words_sent  = 0;
   int burst_left  = 0;

   // stimulus-side copy of the table, used to plant signatures in the stream
   logic [wsm_pkg::BYTE_W-1:0] gen_byte [NSLOT][WLEN];
   logic                       gen_care [NSLOT][WLEN];
   logic [NSLOT-1:0]           gen_loaded = '0;
   int                         gen_seen   = 0;
   int                         gen_align  = int'(wsm_pkg::ALIGN_SHIFT_RESET);
   int                         plant_slot = 0;
   int                         plant_pos  = WLEN;

   wildcard_signature_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: free-running, coin flips, one-in-eight, mostly ready
   always @(posedge clock) begin
      case (cycle_count[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(1) == 1);
         2'd2: rsp_tready <= (cycle_count[2:0] == 3'd0);
         default: rsp_tready <= ($urandom_range(3) != 0);
      endcase
   end

   // results are checked before the same edge's request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_word(wsm_pkg::op_type'(req_tuser), req_tdata);
         if (csr_we) sb.align_shift = csr_wdata;
      end
   end

   task automatic send_word(input wsm_pkg::op_type op,
                            input logic [wsm_pkg::REQ_DATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic load_byte(input logic [wsm_pkg::SLOT_W-1:0] slot,
                            input logic [wsm_pkg::POS_W-1:0] pos,
                            input logic [wsm_pkg::BYTE_W-1:0] b, input logic care);
      gen_byte[slot][pos] = b;
      gen_care[slot][pos] = care;
      gen_loaded[slot]    = 1'b1;
      // stream_start is ignored on a load, so it is random here
      send_word(wsm_pkg::OP_LOAD, {5'd0, 1'($urandom), care, pos, slot, b});
   endtask

   task automatic scan_byte(input logic [wsm_pkg::BYTE_W-1:0] b, input logic start);
      gen_seen = start ? 1 : gen_seen + 1;
      send_word(wsm_pkg::OP_SCAN,
                {5'd0, start, 1'($urandom), 5'($urandom), 4'($urandom), b});
   endtask

   function automatic logic [wsm_pkg::BYTE_W-1:0] noise_byte();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // anchored signature; stale care bits past its end are cleared
   task automatic load_signature();
      int s, len;
      s   = $urandom_range(NSLOT - 1);
      len = ($urandom_range(7) == 0) ? $urandom_range(9, WLEN) : $urandom_range(1, 8);
      for (int p = 0; p < WLEN; p++) begin
         if (p < len)
            load_byte(wsm_pkg::SLOT_W'(s), wsm_pkg::POS_W'(p), 8'($urandom),
                      $urandom_range(5) != 0);
         else if (gen_care[s][p])
            load_byte(wsm_pkg::SLOT_W'(s), wsm_pkg::POS_W'(p), 8'($urandom), 1'b0);
      end
   endtask

   task automatic run_phase(input int n);
      int stop_at, roll, s;
      stop_at = words_sent + n;
      while (words_sent < stop_at) begin
         roll = $urandom_range(99);
         if (plant_pos < WLEN) begin
            if (roll < 5) begin
               load_byte(4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
            end else begin
               scan_byte(gen_care[plant_slot][plant_pos] ? gen_byte[plant_slot][plant_pos]
                                                         : 8'($urandom), 1'b0);
               plant_pos++;
            end
         end else if (roll < 3) begin
            load_signature();
         end else if (roll < 6) begin
            load_byte(4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
         end else if (roll < 7) begin
            scan_byte(noise_byte(), 1'b1);
         end else begin
            s = $urandom_range(NSLOT - 1);
            // start a planted copy only where the window start will be checked
            if (gen_loaded[s] && (gen_seen & ((1 << gen_align) - 1)) == 0
                && $urandom_range(2) == 0) begin
               plant_slot = s;
               plant_pos  = 0;
            end else begin
               scan_byte(noise_byte(), 1'b0);
            end
         end
      end
   endtask

   // idle the sender until every queued report has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_align(input logic [wsm_pkg::SHIFT_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      gen_align  = int'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [wsm_pkg::SHIFT_W-1:0] phase_shift [4];
      phase_shift = '{2'd0, 2'd3, 2'd2, 2'd1};
      sb = new();
      foreach (gen_byte[s, p]) begin
         gen_byte[s][p] = '0;
         gen_care[s][p] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: a full window still reports, with nothing found
      for (int i = 0; i < WLEN; i++)
         scan_byte((i == 1) ? 8'h00 : 8'hFF ^ 8'(i * 37), i == 0);
      load_byte(4'd7, 5'd31, 8'hFF, 1'b0);   // valid slot made only of wildcards
      load_byte(4'd15, 5'd31, 8'h00, 1'b1);
      load_byte(4'd0, 5'd0, 8'hFF, 1'b1);
      for (int i = 0; i < WLEN + 3; i++) begin
         if (i == 16) load_byte(4'd3, 5'd0, 8'hFF, 1'b1);   // load in mid-stream
         scan_byte((i == 0) ? 8'hFF : ((i == WLEN - 1) ? 8'h00 : 8'($urandom)), i == 0);
      end

      foreach (phase_shift[k]) begin
         drain();
         write_align(phase_shift[k]);
         run_phase(PHASE_WORDS);
      end
      drain();

      if (sb.errors == 0 && sb.expected_hits.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
